// File: rtl/sva_pkg.sv
// Package for the synth voice allocator: widths, codes and state types.
// No dependencies; used by the front end, the back end and the top level.
`default_nettype none
package sva_pkg;
  localparam int VOICE_COUNT_DEF = 8;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int AGE_BITS_DEF    = 32;
  localparam int NOTE_W          = 7;
  localparam int IDX_W           = 3;

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_SUSTAIN  = 2'd2,
    ACT_ALL_OFF  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_POLY   = 2'd0,
    MODE_MONO   = 2'd1,
    MODE_UNISON = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  localparam logic [0:0] REG_PLAY_MODE = 1'b0;

  // One queued event between front and back.
  typedef struct packed {
    action_t           action;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] velocity;
    logic              sustain_on;
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STACK,
    ST_APPLY,
    ST_UNI,
    ST_DUMP
  } back_state_t;
endpackage
`default_nettype wire

// File: rtl/sva_front.sv
// Front end of the voice allocator: input beat capture into a small event queue.
// Depends on sva_pkg.
`default_nettype none
module sva_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [1:0]           in_action,
  input  wire [6:0]           in_note,
  input  wire [6:0]           in_velocity,
  input  wire                 in_sustain_on,
  output sva_pkg::event_t     ev,
  output logic                ev_valid,
  input  wire                 ev_take
);
  sva_pkg::event_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign ev_valid = (cnt_r != 2'd0);
  assign pop      = ev_valid && ev_take;
  assign ev       = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // two-entry queue of classified events
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
    if (push) begin
      q_r[wp_r] <= '{action: sva_pkg::action_t'(in_action), note: in_note,
                     velocity: in_velocity, sustain_on: in_sustain_on};
    end
  end
endmodule
`default_nettype wire

// File: rtl/sva_back.sv
// Back end: voice table, held-note stack, age counter and table dump.
// Depends on sva_pkg.
`default_nettype none
module sva_back #(
  parameter int VOICE_COUNT = sva_pkg::VOICE_COUNT_DEF,
  parameter int STACK_DEPTH = sva_pkg::STACK_DEPTH_DEF,
  parameter int AGE_BITS    = sva_pkg::AGE_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  sva_pkg::mode_t    mode,
  input  sva_pkg::event_t   ev,
  input  wire               ev_valid,
  output logic              ev_take,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [2:0]        out_voice_index,
  output logic              out_voice_active,
  output logic              out_voice_held,
  output logic [6:0]        out_voice_note,
  output logic [6:0]        out_voice_velocity,
  output logic              out_last_voice
);
  localparam int VW   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int DUMP = (VOICE_COUNT < 8) ? VOICE_COUNT : 8;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // voice table
  logic [VOICE_COUNT-1:0] act_r, held_r;
  logic [6:0]             vnote_r [VOICE_COUNT];
  logic [6:0]             vvel_r  [VOICE_COUNT];
  logic [AGE_BITS-1:0]    vage_r  [VOICE_COUNT];
  logic [AGE_BITS-1:0]    age_r;
  logic                   sus_r;
  // note stack (no reset; only entries below the count are read)
  logic [6:0]             snote_r [STACK_DEPTH];
  logic [6:0]             svel_r  [STACK_DEPTH];
  logic [CW-1:0]          scnt_r;

  sva_pkg::back_state_t st_r, st_nxt;
  sva_pkg::event_t      ev_r;
  logic [VW:0]          vi_r;       // scan / unison voice pointer
  logic [SW:0]          si_r;       // stack pointer for remove search/shift
  logic                 found_r;    // stack match found
  logic [VW-1:0]        pick_r;
  logic                 freef_r;    // a free voice was found
  logic [VW-1:0]        old_r;      // oldest voice
  logic [2:0]           di_r;

  // newest active voice playing the note, filled during the scan
  logic                 nm_found;
  logic [VW-1:0]        nm_pick;

  logic                 mono_uni, uni;
  logic [VW-1:0]        vi;
  logic [AGE_BITS-1:0]  age_inc;

  assign uni      = (mode == sva_pkg::MODE_UNISON);
  assign mono_uni = (mode == sva_pkg::MODE_MONO) || uni;
  assign vi       = vi_r[VW-1:0];
  assign age_inc  = (age_r != AGE_MAX) ? age_r + 1'b1 : age_r;
  assign ev_take  = (st_r == sva_pkg::ST_IDLE);

  // dump outputs, read from the voice table at the dump index
  logic [VW-1:0] dv;
  assign dv = VW'(di_r);
  assign out_valid          = (st_r == sva_pkg::ST_DUMP);
  assign out_voice_index    = di_r;
  assign out_voice_active   = act_r[dv];
  assign out_voice_held     = held_r[dv];
  assign out_voice_note     = vnote_r[dv];
  assign out_voice_velocity = vvel_r[dv];
  assign out_last_voice     = (di_r == 3'(DUMP - 1));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sva_pkg::ST_IDLE:  if (ev_valid) st_nxt = sva_pkg::ST_STACK;
      sva_pkg::ST_STACK: begin
        if (ev_r.action == sva_pkg::ACT_NOTE_OFF &&
            !(found_r && (SW+1)'(si_r) + 1'b1 >= (SW+1)'(scnt_r)) && si_r != '1)
          st_nxt = sva_pkg::ST_STACK;
        else
          st_nxt = sva_pkg::ST_SCAN;
      end
      sva_pkg::ST_SCAN:  if (vi_r == (VW+1)'(VOICE_COUNT - 1) || vi_r[VW])
                           st_nxt = sva_pkg::ST_APPLY;
      sva_pkg::ST_APPLY: st_nxt = sva_pkg::ST_UNI;
      sva_pkg::ST_UNI:   if (vi_r >= (VW+1)'(VOICE_COUNT - 1)) st_nxt = sva_pkg::ST_DUMP;
      sva_pkg::ST_DUMP:  if (!out_stall && out_last_voice) st_nxt = sva_pkg::ST_IDLE;
      default:           st_nxt = sva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= sva_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // mono/unison target: top of the stack
  logic          top_ok;
  logic [6:0]    top_n, top_v;
  logic [SW-1:0] top_i;
  assign top_ok = (scnt_r != '0);
  assign top_i  = SW'(scnt_r - 1'b1);
  assign top_n  = snote_r[top_i];
  assign top_v  = svel_r[top_i];

  // does this event re-drive voices from the stack
  logic follow;
  always_comb begin
    follow = 1'b0;
    if (mono_uni) begin
      case (ev_r.action)
        sva_pkg::ACT_NOTE_ON:  follow = 1'b1;
        sva_pkg::ACT_NOTE_OFF: follow = !sus_r;
        sva_pkg::ACT_SUSTAIN:  follow = !ev_r.sustain_on;
        default:               follow = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      held_r <= '0;
      age_r  <= '0;
      sus_r  <= 1'b0;
      scnt_r <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        vnote_r[i] <= '0;
        vvel_r[i]  <= '0;
        vage_r[i]  <= '0;
      end
    end else begin
      case (st_r)
        // latch event, prepare the stack step
        sva_pkg::ST_IDLE: begin
          if (ev_valid) begin
            ev_r    <= ev;
            found_r <= 1'b0;
            si_r    <= (SW+1)'(scnt_r) - 1'b1;
          end
        end
        // stack update: push, one step of the remove search or shift, sustain latch, or clear on all off
        sva_pkg::ST_STACK: begin
          vi_r    <= '0;
          freef_r <= 1'b0;
          old_r   <= '0;
          pick_r  <= '0;
          case (ev_r.action)
            sva_pkg::ACT_NOTE_ON: begin
              if (scnt_r >= DEPTH_C) begin
                for (int i = 1; i < STACK_DEPTH; i++) begin
                  snote_r[i-1] <= snote_r[i];
                  svel_r[i-1]  <= svel_r[i];
                end
                snote_r[STACK_DEPTH-1] <= ev_r.note;
                svel_r[STACK_DEPTH-1]  <= ev_r.velocity;
                scnt_r <= DEPTH_C;
              end else begin
                snote_r[SW'(scnt_r)] <= ev_r.note;
                svel_r[SW'(scnt_r)]  <= ev_r.velocity;
                scnt_r <= scnt_r + 1'b1;
              end
            end
            sva_pkg::ACT_NOTE_OFF: begin
              if (!found_r) begin
                if (si_r != '1) begin
                  if (snote_r[SW'(si_r)] == ev_r.note) found_r <= 1'b1;
                  else si_r <= si_r - 1'b1;
                end
              end else begin
                // shift one entry down past the removed slot
                if ((SW+1)'(si_r) + 1'b1 < (SW+1)'(scnt_r)) begin
                  snote_r[SW'(si_r)] <= snote_r[SW'(si_r + 1'b1)];
                  svel_r[SW'(si_r)]  <= svel_r[SW'(si_r + 1'b1)];
                  si_r <= si_r + 1'b1;
                end
              end
              if (found_r && !((SW+1)'(si_r) + 1'b1 < (SW+1)'(scnt_r)))
                scnt_r <= scnt_r - 1'b1;
            end
            sva_pkg::ACT_SUSTAIN: sus_r <= ev_r.sustain_on;
            default: begin
              scnt_r <= '0;
              sus_r  <= 1'b0;
            end
          endcase
        end
        // one voice per cycle: free voice, oldest voice, newest note match
        sva_pkg::ST_SCAN: begin
          if (ev_r.action == sva_pkg::ACT_NOTE_OFF && si_r != '0 && !found_r) begin
            found_r <= 1'b0;
          end
          if (!act_r[vi] && !freef_r) begin
            freef_r <= 1'b1;
            pick_r  <= vi;
          end
          if (vage_r[vi] < vage_r[old_r]) old_r <= vi;
          vi_r <= vi_r + 1'b1;
        end
        // apply the event to the voice table
        sva_pkg::ST_APPLY: begin
          vi_r <= (VW+1)'(1);
          if (ev_r.action == sva_pkg::ACT_ALL_OFF) begin
            act_r  <= '0;
            held_r <= '0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
              vnote_r[i] <= '0; vvel_r[i] <= '0; vage_r[i] <= '0;
            end
          end else if (follow) begin
            if (top_ok) begin
              act_r[0] <= 1'b1; held_r[0] <= 1'b1;
              vnote_r[0] <= top_n; vvel_r[0] <= top_v;
              vage_r[0] <= age_inc; age_r <= age_inc;
            end else begin
              act_r[0] <= 1'b0; held_r[0] <= 1'b0;
              vnote_r[0] <= '0; vvel_r[0] <= '0; vage_r[0] <= '0;
            end
          end else if (!mono_uni) begin
            case (ev_r.action)
              sva_pkg::ACT_NOTE_ON: begin
                act_r[freef_r ? pick_r : old_r]   <= 1'b1;
                held_r[freef_r ? pick_r : old_r]  <= 1'b1;
                vnote_r[freef_r ? pick_r : old_r] <= ev_r.note;
                vvel_r[freef_r ? pick_r : old_r]  <= ev_r.velocity;
                vage_r[freef_r ? pick_r : old_r]  <= age_inc;
                age_r <= age_inc;
              end
              sva_pkg::ACT_NOTE_OFF: begin
                if (nm_found) begin
                  if (sus_r) held_r[nm_pick] <= 1'b0;
                  else begin
                    act_r[nm_pick] <= 1'b0; held_r[nm_pick] <= 1'b0;
                    vnote_r[nm_pick] <= '0; vvel_r[nm_pick] <= '0;
                    vage_r[nm_pick] <= '0;
                  end
                end
              end
              sva_pkg::ACT_SUSTAIN: begin
                if (!ev_r.sustain_on) begin
                  for (int i = 0; i < VOICE_COUNT; i++) begin
                    if (act_r[i] && !held_r[i]) begin
                      act_r[i] <= 1'b0; vnote_r[i] <= '0;
                      vvel_r[i] <= '0; vage_r[i] <= '0;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        // voices 1 upward for mono/unison, one per cycle with own age
        sva_pkg::ST_UNI: begin
          if (VOICE_COUNT > 1 && follow && !vi_r[VW] && vi_r < (VW+1)'(VOICE_COUNT)) begin
            if (top_ok && uni) begin
              act_r[vi] <= 1'b1; held_r[vi] <= 1'b1;
              vnote_r[vi] <= top_n; vvel_r[vi] <= top_v;
              vage_r[vi] <= age_inc; age_r <= age_inc;
            end else begin
              act_r[vi] <= 1'b0; held_r[vi] <= 1'b0;
              vnote_r[vi] <= '0; vvel_r[vi] <= '0; vage_r[vi] <= '0;
            end
          end
          vi_r <= vi_r + 1'b1;
          di_r <= '0;
        end
        sva_pkg::ST_DUMP: if (!out_stall) di_r <= di_r + 1'b1;
        default: ;
      endcase
    end
  end

  // newest active voice playing the note (highest index wins age ties)
  always_ff @(posedge clk) begin
    if (st_r == sva_pkg::ST_STACK) begin
      nm_found <= 1'b0;
      nm_pick  <= '0;
    end else if (st_r == sva_pkg::ST_SCAN) begin
      if (act_r[vi] && vnote_r[vi] == ev_r.note &&
          (!nm_found || vage_r[vi] >= vage_r[nm_pick])) begin
        nm_found <= 1'b1;
        nm_pick  <= vi;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/synth_voice_allocator.sv
// Top level of the synth voice allocator: config port, front queue, back end.
// Depends on sva_pkg, sva_front and sva_back.
//
//   channel | direction | beat
//   in_     | input     | one event: action, note, velocity, sustain_on
//   out_    | output    | one voice record; min(VOICE_COUNT, 8) beats per event
//   p       | APB       | play_mode register, decoded where paddr[2] is 0
//
// An event passes through take, one stack step, a scan over every voice, apply,
// a pass over voices 1 upward and the dump beats. A note off adds stack steps
// to search and compact the stack. Reset is synchronous and clears voices,
// stack count, age and sustain. A stalled output holds the dump; the two-entry
// queue accepts events meanwhile until it is full.
`default_nettype none
module synth_voice_allocator #(
  parameter int VOICE_COUNT = sva_pkg::VOICE_COUNT_DEF,
  parameter int STACK_DEPTH = sva_pkg::STACK_DEPTH_DEF,
  parameter int AGE_BITS    = sva_pkg::AGE_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [1:0]  in_action,
  input  wire [6:0]  in_note,
  input  wire [6:0]  in_velocity,
  input  wire        in_sustain_on,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] out_voice_index,
  output logic       out_voice_active,
  output logic       out_voice_held,
  output logic [6:0] out_voice_note,
  output logic [6:0] out_voice_velocity,
  output logic       out_last_voice,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  sva_pkg::mode_t  mode_r;
  sva_pkg::event_t ev;
  logic            ev_valid, ev_take;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sva_pkg::REG_PLAY_MODE) ? {30'd0, mode_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= sva_pkg::MODE_POLY;
    else if (psel && penable && pwrite && paddr[2] == sva_pkg::REG_PLAY_MODE)
      mode_r <= sva_pkg::mode_t'(pwdata[1:0]);
  end

  sva_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_note, .in_velocity,
    .in_sustain_on, .ev, .ev_valid, .ev_take
  );

  sva_back #(.VOICE_COUNT(VOICE_COUNT), .STACK_DEPTH(STACK_DEPTH),
             .AGE_BITS(AGE_BITS)) u_back (
    .clk, .rst_n, .mode(mode_r), .ev, .ev_valid, .ev_take, .out_valid,
    .out_stall, .out_voice_index, .out_voice_active, .out_voice_held,
    .out_voice_note, .out_voice_velocity, .out_last_voice
  );
endmodule
`default_nettype wire

// File: rtl/sva_checker.sv
// Port-level checker for the synth voice allocator, bound to the top level.
// Depends on synth_voice_allocator ports only.
`default_nettype none
module sva_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_stall,
  input wire [2:0] out_voice_index,
  input wire       out_last_voice,
  input wire       out_voice_active,
  input wire       out_voice_held,
  input wire       pready
);
  // a stalled beat holds its index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_voice_index))
    else $error("dump beat changed under stall");
  // a held mark never shows on an idle voice
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_voice_held |-> out_voice_active)
    else $error("held voice not active");
  // dump ends on the last voice
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_voice |-> out_voice_index == 3'd7)
    else $error("last marker misplaced");
  // a delivered beat that is not last is followed by the next index
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_voice |=>
      out_valid && out_voice_index == $past(out_voice_index) + 3'd1)
    else $error("dump index skipped");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind synth_voice_allocator sva_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_voice_index,
  .out_last_voice, .out_voice_active, .out_voice_held, .pready
);
`default_nettype wire
